@@ hdl/conv3x3_pkg.sv @@
// Package with types, register indexes and constants of the 3x3 convolution unit.
`default_nettype none
package conv3x3_pkg;

  localparam int unsigned MaxWidthDefault  = 1024;
  localparam int unsigned MaxHeightDefault = 1024;
  localparam int unsigned CfgIndexWidth    = 3;
  localparam int unsigned CfgDataWidth     = 24;

  localparam logic [CfgIndexWidth-1:0] RegImageWidth  = 3'd0;
  localparam logic [CfgIndexWidth-1:0] RegImageHeight = 3'd1;
  localparam logic [CfgIndexWidth-1:0] RegKernelTop   = 3'd2;
  localparam logic [CfgIndexWidth-1:0] RegKernelMid   = 3'd3;
  localparam logic [CfgIndexWidth-1:0] RegKernelBot   = 3'd4;
  localparam logic [CfgIndexWidth-1:0] RegDivisor     = 3'd5;
  localparam logic [CfgIndexWidth-1:0] RegBias        = 3'd6;

  localparam logic [7:0] SatMax = 8'd255;

  typedef struct packed {
    logic [7:0] blue_in;
    logic [7:0] green_in;
    logic [7:0] red_in;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [9:0] centre_row;
    logic [9:0] centre_col;
    logic       frame_last;
  } pixel_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;       // capture a pixel and start the line store read
    logic       shift;      // complete the window shift with line store data
    logic       mac_clear;  // clear accumulators
    logic       mac_step;   // accumulate one tap
    logic [3:0] tap;        // tap index 0..8
    logic       div_start;  // start the divider
    logic       finish;     // form the output values
  } conv_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
  } conv_status_t;

endpackage
`default_nettype wire

@@ hdl/conv3x3_datapath.sv @@
// Datapath of the 3x3 convolution unit: line stores, window, MAC and serial divider.
`default_nettype none
module conv3x3_datapath #(
  parameter int unsigned MAX_WIDTH = conv3x3_pkg::MaxWidthDefault,
  parameter int unsigned COL_BITS  = 10
) (
  input  wire logic                      clk,
  input  wire conv3x3_pkg::conv_cmd_t    cmd,
  output conv3x3_pkg::conv_status_t      status,
  input  wire conv3x3_pkg::pixel_in_t    pixel,
  input  wire logic [COL_BITS-1:0]       col,
  input  wire logic [71:0]               kernel,
  input  wire logic [9:0]                divisor,
  input  wire logic [7:0]                bias,
  output logic [7:0]                     red_val,
  output logic [7:0]                     green_val,
  output logic [7:0]                     blue_val
);
  import conv3x3_pkg::*;

  localparam int unsigned AddrBits = $clog2(MAX_WIDTH);

  logic [23:0] line_a [MAX_WIDTH];
  logic [23:0] line_b [MAX_WIDTH];
  logic [23:0] rd_a;
  logic [23:0] rd_b;
  logic [23:0] win [9];
  logic [23:0] px_hold;
  logic [AddrBits-1:0] addr;
  logic [AddrBits-1:0] addr_hold;

  // Sums need 20 bits signed (9 * 255 * 128 = 293760).
  logic signed [19:0] acc [3];
  logic [18:0] mag [3];
  logic [18:0] quo [3];
  logic [18:0] rem [3];
  logic [18:0] rem_trial [3];
  logic [4:0]  div_cnt;
  logic        div_busy;
  logic        bypass;

  assign addr = col[AddrBits-1:0];

  // Line store reads; data is registered and used in the following cycle.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rd_a      <= line_a[addr];
      rd_b      <= line_b[addr];
      px_hold   <= pixel;
      addr_hold <= addr;
    end
  end

  // Line store writes happen once the old data has been read.
  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      line_a[addr_hold] <= px_hold;
      line_b[addr_hold] <= rd_a;
    end
  end

  // Window shift: taps move left, the new column enters on the right.
  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      for (int k = 0; k < 3; k++) begin
        win[k*3]   <= win[k*3+1];
        win[k*3+1] <= win[k*3+2];
      end
      win[2] <= rd_b;
      win[5] <= rd_a;
      win[8] <= px_hold;
    end
  end

  // One tap per cycle for all three lanes; operands are extended to the
  // accumulator width before the product is formed.
  always_ff @(posedge clk) begin
    logic signed [7:0] cf;
    logic [23:0]       tp;
    cf = kernel[cmd.tap*8 +: 8];
    tp = win[cmd.tap];
    if (cmd.mac_clear) begin
      for (int l = 0; l < 3; l++) acc[l] <= '0;
    end else if (cmd.mac_step) begin
      for (int l = 0; l < 3; l++) begin
        acc[l] <= acc[l] + $signed({12'd0, tp[l*8 +: 8]}) * $signed({{12{cf[7]}}, cf});
      end
    end
  end

  // Restoring divider on magnitudes, one quotient bit per cycle.
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      rem_trial[l] = {rem[l][17:0], quo[l][18]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      bypass   <= (divisor <= 10'd1);
      div_cnt  <= 5'd19;
      div_busy <= 1'b1;
      for (int l = 0; l < 3; l++) begin
        quo[l] <= acc[l][19] ? 19'(-acc[l]) : acc[l][18:0];
        rem[l] <= '0;
      end
    end else if (div_busy) begin
      if (bypass || div_cnt == 5'd0) begin
        div_busy <= 1'b0;
      end else begin
        div_cnt <= div_cnt - 5'd1;
        for (int l = 0; l < 3; l++) begin
          if (rem_trial[l] >= {9'd0, divisor}) begin
            rem[l] <= rem_trial[l] - {9'd0, divisor};
            quo[l] <= {quo[l][17:0], 1'b1};
          end else begin
            rem[l] <= rem_trial[l];
            quo[l] <= {quo[l][17:0], 1'b0};
          end
        end
      end
    end else begin
      div_busy <= 1'b0;
    end
  end

  assign status.div_done = div_busy && (bypass || div_cnt == 5'd0);

  // Bias and saturation.
  always_comb begin
    for (int l = 0; l < 3; l++) mag[l] = quo[l] + {11'd0, bias};
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      red_val   <= (mag[0] > 19'd255) ? SatMax : mag[0][7:0];
      green_val <= (mag[1] > 19'd255) ? SatMax : mag[1][7:0];
      blue_val  <= (mag[2] > 19'd255) ? SatMax : mag[2][7:0];
    end
  end

endmodule
`default_nettype wire

@@ hdl/conv3x3_ctrl.sv @@
// Controller of the 3x3 convolution unit: handshakes, position counters and sequencing.
`default_nettype none
module conv3x3_ctrl #(
  parameter int unsigned MAX_WIDTH  = conv3x3_pkg::MaxWidthDefault,
  parameter int unsigned MAX_HEIGHT = conv3x3_pkg::MaxHeightDefault,
  parameter int unsigned COL_BITS   = 10,
  parameter int unsigned ROW_BITS   = 10
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  input  wire logic [10:0]               image_width,
  input  wire logic [10:0]               image_height,
  output conv3x3_pkg::conv_cmd_t         cmd,
  input  wire conv3x3_pkg::conv_status_t status,
  output logic [COL_BITS-1:0]            col,
  output logic [9:0]                     centre_row,
  output logic [9:0]                     centre_col,
  output logic                           frame_last
);
  import conv3x3_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SHIFT, S_MAC, S_DIV_START, S_DIV, S_FIN, S_OUT
  } state_t;

  localparam int unsigned DimBits = (COL_BITS > ROW_BITS ? COL_BITS : ROW_BITS) + 2;

  state_t              state;
  logic [COL_BITS-1:0] col_count;
  logic [ROW_BITS-1:0] row_count;
  logic [DimBits-1:0]  w;
  logic [DimBits-1:0]  h;
  logic [DimBits-1:0]  c;
  logic [DimBits-1:0]  r;
  logic                row_end;
  logic                frame_end;
  logic                emit;
  logic                emit_next;
  logic [3:0]          tap;
  logic [ROW_BITS-1:0] row_hold;
  logic [COL_BITS-1:0] col_hold;
  logic                last_hold;
  logic                accept;

  // Clamp geometry and current position.
  always_comb begin
    w = DimBits'(image_width);
    h = DimBits'(image_height);
    if (w < DimBits'(3)) w = DimBits'(3);
    if (w > DimBits'(MAX_WIDTH)) w = DimBits'(MAX_WIDTH);
    if (h < DimBits'(3)) h = DimBits'(3);
    if (h > DimBits'(MAX_HEIGHT)) h = DimBits'(MAX_HEIGHT);
    c = DimBits'(col_count);
    r = DimBits'(row_count);
    if (c >= w) c = w - DimBits'(1);
    if (r >= h) r = h - DimBits'(1);
    row_end   = (c >= w - DimBits'(1));
    frame_end = row_end && (r >= h - DimBits'(1));
    emit_next = (r >= DimBits'(2)) && (c >= DimBits'(2));
  end

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign col      = c[COL_BITS-1:0];

  // Command decode; the divider starts only after the last tap has been added.
  always_comb begin
    cmd           = '0;
    cmd.load      = accept;
    cmd.shift     = (state == S_SHIFT);
    cmd.mac_clear = (state == S_SHIFT);
    cmd.mac_step  = (state == S_MAC);
    cmd.tap       = tap;
    cmd.div_start = (state == S_DIV_START);
    cmd.finish    = (state == S_FIN);
  end

  // Sequencer, counters and the output beat register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      col_count <= '0;
      row_count <= '0;
      out_valid <= 1'b0;
      tap       <= '0;
      emit      <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            emit      <= emit_next;
            row_hold  <= ROW_BITS'(r - DimBits'(1));
            col_hold  <= COL_BITS'(c - DimBits'(1));
            last_hold <= frame_end;
            if (row_end) begin
              col_count <= '0;
              row_count <= frame_end ? '0 : ROW_BITS'(r + DimBits'(1));
            end else begin
              col_count <= COL_BITS'(c + DimBits'(1));
              row_count <= ROW_BITS'(r);
            end
            state <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          tap   <= '0;
          state <= emit ? S_MAC : S_IDLE;
        end
        S_MAC: begin
          if (tap == 4'd8) begin
            state <= S_DIV_START;
          end else begin
            tap <= tap + 4'd1;
          end
        end
        S_DIV_START: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (status.div_done) state <= S_FIN;
        end
        S_FIN: begin
          out_valid  <= 1'b1;
          centre_row <= 10'(row_hold);
          centre_col <= 10'(col_hold);
          frame_last <= last_hold;
          state      <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ hdl/convolution_3x3_saturating_unit.sv @@
// Top level of the 3x3 saturating convolution unit: configuration registers and wiring.
`default_nettype none
// Accepts raster-order RGB pixels and, for each interior pixel, returns one
// beat with the three filtered channels (sum of nine taps times signed
// coefficients, divided with truncation toward zero, absolute value plus
// bias, saturated at 255) and the window-centre coordinates; border pixels
// give no beat. One pixel is worked on at a time: a border pixel is
// accepted and then shifts the window. An interior pixel is accepted,
// shifts the window, runs the shared multiply-accumulate over the nine
// taps, starts the divider, passes through the one-bit-per-cycle divider
// (bypassed when the divisor is 0 or 1), registers the result and then
// offers the result beat until it is taken; a stalled result beat holds
// the unit. Line stores are undefined after reset and need no clearing
// pass.
module convolution_3x3_saturating_unit #(
  parameter int unsigned MAX_WIDTH  = conv3x3_pkg::MaxWidthDefault,
  parameter int unsigned MAX_HEIGHT = conv3x3_pkg::MaxHeightDefault
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire conv3x3_pkg::pixel_in_t                 in_data,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output conv3x3_pkg::pixel_out_t                     out_data,
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [conv3x3_pkg::CfgIndexWidth-1:0]  cfg_index,
  input  wire logic [conv3x3_pkg::CfgDataWidth-1:0]   cfg_data
);
  import conv3x3_pkg::*;

  localparam int unsigned ColBits = $clog2(MAX_WIDTH) < 10 ? 10 : $clog2(MAX_WIDTH);
  localparam int unsigned RowBits = $clog2(MAX_HEIGHT) < 10 ? 10 : $clog2(MAX_HEIGHT);

  logic [10:0] image_width;
  logic [10:0] image_height;
  logic [23:0] kernel_row_top;
  logic [23:0] kernel_row_middle;
  logic [23:0] kernel_row_bottom;
  logic [9:0]  divisor;
  logic [7:0]  bias;

  conv_cmd_t           cmd;
  conv_status_t        status;
  logic [ColBits-1:0]  col;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width       <= 11'd640;
      image_height      <= 11'd480;
      kernel_row_top    <= 24'd0;
      kernel_row_middle <= 24'd256;
      kernel_row_bottom <= 24'd0;
      divisor           <= 10'd1;
      bias              <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        RegImageWidth:  image_width       <= cfg_data[10:0];
        RegImageHeight: image_height      <= cfg_data[10:0];
        RegKernelTop:   kernel_row_top    <= cfg_data;
        RegKernelMid:   kernel_row_middle <= cfg_data;
        RegKernelBot:   kernel_row_bottom <= cfg_data;
        RegDivisor:     divisor           <= cfg_data[9:0];
        RegBias:        bias              <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  conv3x3_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .COL_BITS  (ColBits),
    .ROW_BITS  (RowBits)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .image_width (image_width),
    .image_height(image_height),
    .cmd         (cmd),
    .status      (status),
    .col         (col),
    .centre_row  (out_data.centre_row),
    .centre_col  (out_data.centre_col),
    .frame_last  (out_data.frame_last)
  );

  conv3x3_datapath #(
    .MAX_WIDTH(MAX_WIDTH),
    .COL_BITS (ColBits)
  ) u_dp (
    .clk      (clk),
    .cmd      (cmd),
    .status   (status),
    .pixel    (in_data),
    .col      (col),
    .kernel   ({kernel_row_bottom, kernel_row_middle, kernel_row_top}),
    .divisor  (divisor),
    .bias     (bias),
    .red_val  (out_data.red_out),
    .green_val(out_data.green_out),
    .blue_val (out_data.blue_out)
  );

  // A pending result beat blocks new pixels.
  a_out_blocks_in: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("pixel accepted while a result is pending");

  // A result never appears in the cycle after a pixel is accepted.
  a_no_early_out: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> !out_valid) else $error("result too early");

  // A MAC step and the divider start are never issued together.
  a_cmd_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.mac_step && cmd.div_start)) else $error("command overlap");

endmodule
`default_nettype wire

@@ sim/tb_convolution_3x3_saturating_unit.sv @@
// Self-checking testbench of the 3x3 saturating convolution unit.
`default_nettype none
module tb_convolution_3x3_saturating_unit;
  import conv3x3_pkg::*;

  // Predicts the filtered beats of the unit and checks the beats that come out.
  class conv_scoreboard;
    logic [10:0] width_reg, height_reg;
    logic [23:0] kernel_row [3];
    logic [9:0]  divisor_reg;
    logic [7:0]  bias_reg;
    logic [23:0] line_prev [1024];
    logic [23:0] line_older [1024];
    logic [23:0] window [9];
    int          row_pos, col_pos;
    pixel_out_t  pending [$];
    int          mismatches;
    int          beats_checked;

    function new();
      width_reg     = 11'd640;
      height_reg    = 11'd480;
      kernel_row[0] = 24'h000000;
      kernel_row[1] = 24'h000100;
      kernel_row[2] = 24'h000000;
      divisor_reg   = 10'd1;
      bias_reg      = 8'd0;
      foreach (line_prev[i]) begin
        line_prev[i]  = '0;
        line_older[i] = '0;
      end
      foreach (window[i]) window[i] = '0;
      row_pos       = 0;
      col_pos       = 0;
      mismatches    = 0;
      beats_checked = 0;
    endfunction

    function void write_reg(logic [CfgIndexWidth-1:0] idx, logic [CfgDataWidth-1:0] data);
      case (idx)
        RegImageWidth:  width_reg     = data[10:0];
        RegImageHeight: height_reg    = data[10:0];
        RegKernelTop:   kernel_row[0] = data;
        RegKernelMid:   kernel_row[1] = data;
        RegKernelBot:   kernel_row[2] = data;
        RegDivisor:     divisor_reg   = data[9:0];
        RegBias:        bias_reg      = data[7:0];
        default: ;
      endcase
    endfunction

    function int clamp_dim(int v);
      if (v < 3) return 3;
      if (v > 1024) return 1024;
      return v;
    endfunction

    // One channel: weighted sum, division toward zero, magnitude, bias, saturation.
    function logic [7:0] filter_lane(int ch);
      int sum, pv, dv, mag;
      logic signed [7:0] k;
      sum = 0;
      dv  = (divisor_reg == 0) ? 1 : int'(divisor_reg);
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++) begin
          pv  = window[r*3+c][8*ch +: 8];
          k   = kernel_row[r][8*c +: 8];
          sum += pv * int'(k);
        end
      if (dv != 1) sum = sum / dv;
      mag = (sum < 0) ? -sum : sum;
      mag += bias_reg;
      return (mag > 255) ? SatMax : mag[7:0];
    endfunction

    // Called for every accepted input beat.
    function void note_pixel(pixel_in_t p);
      int w, h, c, r;
      bit row_end, frame_end;
      logic [23:0] px;
      pixel_out_t res;
      w  = clamp_dim(width_reg);
      h  = clamp_dim(height_reg);
      c  = (col_pos >= w) ? w - 1 : col_pos;
      r  = (row_pos >= h) ? h - 1 : row_pos;
      px = {p.blue_in, p.green_in, p.red_in};
      row_end   = (c >= w - 1);
      frame_end = row_end && (r >= h - 1);
      for (int k = 0; k < 3; k++) begin
        window[k*3]   = window[k*3+1];
        window[k*3+1] = window[k*3+2];
      end
      window[2]     = line_older[c];
      window[5]     = line_prev[c];
      window[8]     = px;
      line_older[c] = line_prev[c];
      line_prev[c]  = px;
      if (r >= 2 && c >= 2) begin
        res.red_out    = filter_lane(0);
        res.green_out  = filter_lane(1);
        res.blue_out   = filter_lane(2);
        res.centre_row = 10'(r - 1);
        res.centre_col = 10'(c - 1);
        res.frame_last = frame_end;
        pending.push_back(res);
      end
      if (row_end) begin
        col_pos = 0;
        row_pos = frame_end ? 0 : ((r + 1) & 10'h3FF);
      end else begin
        col_pos = (c + 1) & 10'h3FF;
        row_pos = r;
      end
    endfunction

    // Called for every accepted output beat.
    function void check_result(pixel_out_t got);
      pixel_out_t want;
      beats_checked++;
      if (pending.size() == 0) begin
        $error("unexpected output beat %h", got);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      if (got.red_out !== want.red_out) begin
        $error("red_out expected %0d actual %0d", want.red_out, got.red_out);
        mismatches++;
      end
      if (got.green_out !== want.green_out) begin
        $error("green_out expected %0d actual %0d", want.green_out, got.green_out);
        mismatches++;
      end
      if (got.blue_out !== want.blue_out) begin
        $error("blue_out expected %0d actual %0d", want.blue_out, got.blue_out);
        mismatches++;
      end
      if (got.centre_row !== want.centre_row) begin
        $error("centre_row expected %0d actual %0d", want.centre_row, got.centre_row);
        mismatches++;
      end
      if (got.centre_col !== want.centre_col) begin
        $error("centre_col expected %0d actual %0d", want.centre_col, got.centre_col);
        mismatches++;
      end
      if (got.frame_last !== want.frame_last) begin
        $error("frame_last expected %0d actual %0d", want.frame_last, got.frame_last);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  pixel_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  pixel_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIndexWidth-1:0] cfg_index = RegImageWidth;
  logic [CfgDataWidth-1:0]  cfg_data = '0;

  conv_scoreboard sb = new();
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  bit hold_req = 1'b0;
  int pixels_sent = 0;
  int frames_sent = 0;

  convolution_3x3_saturating_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Output beats are checked at the rising edge.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Receiver: random stalls per beat, calm stretches, and one long hold-off.
  initial begin
    int gap;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (400) @(negedge clk);
        hold_req = 1'b0;
      end
      gap = rx_calm ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
        out_stall = 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Run limit.
  initial begin
    #12000000;
    $display("tb_convolution_3x3_saturating_unit failed");
    $finish;
  end

  task automatic write_cfg(logic [CfgIndexWidth-1:0] idx, logic [CfgDataWidth-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Sends one pixel beat; called at a falling edge, returns at a falling edge once the beat is accepted.
  task automatic send_pixel(pixel_in_t px);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = px;
    do @(posedge clk); while (in_stall);
    sb.note_pixel(px);
    pixels_sent++;
    @(negedge clk);
  endtask

  // Waits until every expected beat has come, then idles with the input low.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    wait (sb.pending.size() == 0);
    repeat (40) @(posedge clk);
  endtask

  function automatic pixel_in_t rand_pixel();
    return pixel_in_t'(24'($urandom));
  endfunction

  // A whole frame; mode 0 random, 1 all bits low and high alternating, 2 all high.
  task automatic send_frame(int w, int h, int mode);
    pixel_in_t px;
    @(negedge clk);
    for (int i = 0; i < w * h; i++) begin
      case (mode)
        1:       px = (i % 2) ? '1 : '0;
        2:       px = '1;
        default: px = rand_pixel();
      endcase
      send_pixel(px);
    end
    frames_sent++;
    drain();
  endtask

  function automatic logic [23:0] small_kernel_row();
    logic [23:0] v;
    for (int k = 0; k < 3; k++) v[8*k +: 8] = 8'($signed($urandom_range(0, 8)) - 4);
    return v;
  endfunction

  // Main sequence.
  initial begin
    int w, h;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Geometry below the minimum is clamped; kernel is still the reset identity.
    write_cfg(RegImageWidth, 24'd2);
    write_cfg(RegImageHeight, 24'd0);
    send_frame(3, 3, 1);

    // Most negative taps on full pixels, zero divisor, largest bias.
    write_cfg(RegKernelTop, 24'h808080);
    write_cfg(RegKernelMid, 24'h808080);
    write_cfg(RegKernelBot, 24'h808080);
    write_cfg(RegDivisor, 24'd0);
    write_cfg(RegBias, 24'd255);
    write_cfg(RegImageHeight, 24'd3);
    send_frame(3, 3, 2);

    // Most positive taps, largest divisor.
    write_cfg(RegKernelTop, 24'h7F7F7F);
    write_cfg(RegKernelMid, 24'h7F7F7F);
    write_cfg(RegKernelBot, 24'h7F7F7F);
    write_cfg(RegDivisor, 24'd1023);
    write_cfg(RegBias, 24'd0);
    send_frame(3, 3, 0);

    // Random frames with random geometry, kernels and idling.
    for (int f = 0; f < 14; f++) begin
      w = $urandom_range(3, 12);
      h = $urandom_range(3, 6);
      write_cfg(RegImageWidth, 24'(w));
      write_cfg(RegImageHeight, 24'(h));
      if ($urandom_range(0, 1)) begin
        write_cfg(RegKernelTop, small_kernel_row());
        write_cfg(RegKernelMid, small_kernel_row());
        write_cfg(RegKernelBot, small_kernel_row());
        write_cfg(RegDivisor, 24'($urandom_range(1, 20)));
      end else begin
        write_cfg(RegKernelTop, 24'($urandom));
        write_cfg(RegKernelMid, 24'($urandom));
        write_cfg(RegKernelBot, 24'($urandom));
        write_cfg(RegDivisor, 24'($urandom_range(0, 1023)));
      end
      write_cfg(RegBias, 24'($urandom_range(0, 255)));
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      if (f == 4) begin
        tx_calm  = 1'b1;
        hold_req = 1'b1;
      end
      send_frame(w, h, 0);
    end

    $display("Covered %0d frames, %0d pixels and %0d output beats,", frames_sent,
             pixels_sent, sb.beats_checked);
    $display("including clamped geometry, extreme taps, divisors and a long output hold-off.");
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("tb_convolution_3x3_saturating_unit passed");
    end else begin
      $display("tb_convolution_3x3_saturating_unit failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
